FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define RMQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rmq assertion failed");

// Expression must never be true outside reset.
`define RMQ_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("rmq forbidden condition seen");

`endif

FILE: rtl/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int FRAC_BITS = 16;
	localparam int FW        = 18;                   // field width
	localparam int T_W       = FW + 3;               // signed trace / t
	localparam int DS_W      = FW + 1;               // signed sum of two entries
	localparam int MAG_W     = FW + 1;               // magnitude of such a sum
	localparam int N_W       = FW + 1 + FRAC_BITS;   // t << FRAC_BITS, t positive
	localparam int R_W       = (N_W + 1) / 2;        // root bits
	localparam int SQ_W      = 2 * R_W + 1;          // root remainder / accumulator
	localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
	localparam int DV_W      = R_W + 1;              // divisor 2r
	localparam int QB        = FW;                   // quotient bits before overflow
	localparam int P_W       = NUM_W + 1;

	localparam logic signed [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;
	localparam logic signed [FW-1:0] OUT_MAX = {1'b0, {(FW-1){1'b1}}};
	localparam logic signed [FW-1:0] OUT_MIN = {1'b1, {(FW-1){1'b0}}};

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	// side data that rides along the root pipeline
	typedef struct packed {
		logic [1:0]            br;
		logic                  bad;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} rmq_side_t;

	// side data that rides along the divider pipeline
	typedef struct packed {
		logic [1:0]          br;
		logic                bad;
		logic [FW-1:0]       mainc;
		logic [2:0]          neg;
		logic [2:0]          ovf;
		logic [DV_W-1:0]     dvs;
	} rmq_dside_t;

	// Saturate a signed quotient given as sign and magnitude.
	function automatic logic signed [FW-1:0] sat_lane(input logic neg, input logic ovf,
			input logic [QB-1:0] q);
		logic big;
		big = ovf || q[QB-1];
		if (neg) begin
			sat_lane = big ? OUT_MIN : -$signed(q);
		end else begin
			sat_lane = big ? OUT_MAX : $signed(q);
		end
	endfunction
endpackage

FILE: rtl/rmq_mat_if.sv
`timescale 1ns / 1ps
interface rmq_mat_if;
	import rmq_pkg::*;
	logic valid;
	logic ready;
	logic signed [FW-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
	modport source(output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
		input ready);
	modport sink(input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
		output ready);
endinterface

FILE: rtl/rmq_quat_if.sv
`timescale 1ns / 1ps
interface rmq_quat_if;
	import rmq_pkg::*;
	logic valid;
	logic ready;
	logic signed [FW-1:0] quat_x, quat_y, quat_z, quat_w;
	logic bad_input;
	modport source(output valid, quat_x, quat_y, quat_z, quat_w, bad_input, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, bad_input, output ready);
endinterface

FILE: rtl/rotation_matrix_to_quaternion_core.sv
`timescale 1ns / 1ps
// Rotation matrix to unit quaternion (Shepperd's method) in signed Q2.16.
// Takes one 3x3 rotation matrix per cycle and returns (x, y, z, w) plus a
// bad_input flag (t not positive: components zero). It is built from
// one setup stage (trace, branch, numerators), 18 stages of a bit-per-stage
// square root, one divider setup stage, 18 stages of a bit-per-stage divider
// running three lanes side by side, and the output register. Throughput is one
// item per cycle; the whole pipeline holds while the output item is not taken.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_core (
	input logic clk,
	input logic arst_n,
	rmq_mat_if.sink mat,
	rmq_quat_if.source quat
);
	import rmq_pkg::*;

	logic en;

	// root pipeline
	logic [R_W:0]    sq_v_s;
	logic [SQ_W-1:0] sq_rem_s  [R_W+1];
	logic [SQ_W-1:0] sq_res_s  [R_W+1];
	rmq_side_t       sq_side_s [R_W+1];

	// divider pipeline
	logic [QB:0]           dv_v_s;
	rmq_dside_t            dv_side_s [QB+1];
	logic [2:0][P_W-1:0]   dv_p_s    [QB+1];
	logic [2:0][QB-1:0]    dv_q_s    [QB+1];

	// output register
	logic                 out_v_q;
	logic signed [FW-1:0] qx_q, qy_q, qz_q, qw_q;
	logic                 bad_q;

	// advance everything unless the output item is stuck
	assign en = !out_v_q || quat.ready;
	assign mat.ready = en;

	// setup: trace, branch, t and the three off-diagonal numerators
	logic signed [T_W-1:0]  e11, e22, e33, tr, t;
	logic [1:0]             br;
	logic                   bad;
	logic signed [DS_W-1:0] d [3];
	rmq_side_t              side_in;
	logic [SQ_W-1:0]        n_in;

	always_comb begin
		e11 = T_W'(mat.r11);
		e22 = T_W'(mat.r22);
		e33 = T_W'(mat.r33);
		tr  = e11 + e22 + e33;
		if (tr > 0) begin
			br = BR_TRACE;
			t  = ONE_T + tr;
		end else if (mat.r11 > mat.r22 && mat.r11 > mat.r33) begin
			br = BR_X;
			t  = ONE_T + e11 - e22 - e33;
		end else if (mat.r22 > mat.r33) begin
			br = BR_Y;
			t  = ONE_T + e22 - e11 - e33;
		end else begin
			br = BR_Z;
			t  = ONE_T + e33 - e11 - e22;
		end
		bad = (t <= 0);
		case (br)
			BR_TRACE: begin
				d[0] = DS_W'(mat.r23) - DS_W'(mat.r32);
				d[1] = DS_W'(mat.r31) - DS_W'(mat.r13);
				d[2] = DS_W'(mat.r12) - DS_W'(mat.r21);
			end
			BR_X: begin
				d[0] = DS_W'(mat.r12) + DS_W'(mat.r21);
				d[1] = DS_W'(mat.r13) + DS_W'(mat.r31);
				d[2] = DS_W'(mat.r23) - DS_W'(mat.r32);
			end
			BR_Y: begin
				d[0] = DS_W'(mat.r12) + DS_W'(mat.r21);
				d[1] = DS_W'(mat.r23) + DS_W'(mat.r32);
				d[2] = DS_W'(mat.r31) - DS_W'(mat.r13);
			end
			default: begin
				d[0] = DS_W'(mat.r31) + DS_W'(mat.r13);
				d[1] = DS_W'(mat.r32) + DS_W'(mat.r23);
				d[2] = DS_W'(mat.r12) - DS_W'(mat.r21);
			end
		endcase
		side_in.br  = br;
		side_in.bad = bad;
		for (int k = 0; k < 3; k++) begin
			side_in.neg[k] = d[k][DS_W-1];
			side_in.mag[k] = d[k][DS_W-1] ? MAG_W'(-d[k]) : MAG_W'(d[k]);
		end
		n_in = bad ? '0 : SQ_W'(N_W'(t[FW:0]) << FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= mat.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]  <= n_in;
			sq_res_s[0]  <= '0;
			sq_side_s[0] <= side_in;
		end
	end

	// square root: one result bit per stage
	for (genvar k = 0; k < R_W; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (R_W - 1 - k));
		logic [SQ_W-1:0] trial;
		assign trial = sq_res_s[k] + SQ_BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[k+1] <= sq_side_s[k];
				if (sq_rem_s[k] >= trial) begin
					sq_rem_s[k+1] <= sq_rem_s[k] - trial;
					sq_res_s[k+1] <= (sq_res_s[k] >> 1) + SQ_BIT;
				end else begin
					sq_rem_s[k+1] <= sq_rem_s[k];
					sq_res_s[k+1] <= sq_res_s[k] >> 1;
				end
			end
		end
	end

	// divider setup: main component, numerators, divisor, overflow check
	logic [R_W-1:0]      root;
	logic [R_W:0]        root_inc;
	logic [DV_W-1:0]     dvs;
	logic [P_W-1:0]      dvs_top;
	rmq_dside_t          dside_in;
	logic [2:0][P_W-1:0] p_in;

	always_comb begin
		root     = sq_res_s[R_W][R_W-1:0];
		root_inc = {1'b0, root} + 1'b1;
		dvs      = {root, 1'b0};
		dvs_top  = P_W'(dvs) << QB;
		dside_in.br    = sq_side_s[R_W].br;
		dside_in.bad   = sq_side_s[R_W].bad;
		dside_in.mainc = FW'(root_inc[R_W:1]);
		dside_in.neg   = sq_side_s[R_W].neg;
		dside_in.dvs   = dvs;
		for (int k = 0; k < 3; k++) begin
			p_in[k] = P_W'({sq_side_s[R_W].mag[k], {FRAC_BITS{1'b0}}}) + P_W'(root);
			dside_in.ovf[k] = (p_in[k] >= dvs_top);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[R_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s[0] <= dside_in;
			dv_p_s[0]    <= p_in;
			dv_q_s[0]    <= '0;
		end
	end

	// restoring division: one quotient bit per stage, three lanes
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int QBIT = QB - 1 - k;
		logic [P_W-1:0] trial;
		assign trial = P_W'(dv_side_s[k].dvs) << QBIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[k+1] <= dv_side_s[k];
				for (int j = 0; j < 3; j++) begin
					if (dv_p_s[k][j] >= trial) begin
						dv_p_s[k+1][j] <= dv_p_s[k][j] - trial;
						dv_q_s[k+1][j] <= dv_q_s[k][j] | (QB'(1) << QBIT);
					end else begin
						dv_p_s[k+1][j] <= dv_p_s[k][j];
						dv_q_s[k+1][j] <= dv_q_s[k][j];
					end
				end
			end
		end
	end

	// saturate lanes and place them around the main component
	logic signed [FW-1:0] lane [3];
	logic signed [FW-1:0] mainc, ox, oy, oz, ow;
	rmq_dside_t           fs;

	always_comb begin
		fs    = dv_side_s[QB];
		mainc = $signed(fs.mainc);
		for (int k = 0; k < 3; k++) begin
			lane[k] = sat_lane(fs.neg[k], fs.ovf[k], dv_q_s[QB][k]);
		end
		case (fs.br)
			BR_TRACE: begin
				ox = lane[0]; oy = lane[1]; oz = lane[2]; ow = mainc;
			end
			BR_X: begin
				ox = mainc; oy = lane[0]; oz = lane[1]; ow = lane[2];
			end
			BR_Y: begin
				ox = lane[0]; oy = mainc; oz = lane[1]; ow = lane[2];
			end
			default: begin
				ox = lane[0]; oy = lane[1]; oz = mainc; ow = lane[2];
			end
		endcase
		if (fs.bad) begin
			ox = '0; oy = '0; oz = '0; ow = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_q  <= ox;
			qy_q  <= oy;
			qz_q  <= oz;
			qw_q  <= ow;
			bad_q <= fs.bad;
		end
	end

	assign quat.valid     = out_v_q;
	assign quat.quat_x    = qx_q;
	assign quat.quat_y    = qy_q;
	assign quat.quat_z    = qz_q;
	assign quat.quat_w    = qw_q;
	assign quat.bad_input = bad_q;

	// all four output components are zero
	logic out_zero;
	assign out_zero = (qx_q == '0) && (qy_q == '0) && (qz_q == '0) && (qw_q == '0);

	// a flagged item carries zero components
	`RMQ_ASSERT(a_bad_zero, clk, arst_n, quat.valid && quat.bad_input |-> out_zero)
	// a stall freezes every stage
	`RMQ_ASSERT(a_stall_hold, clk, arst_n, !en |=> $stable(sq_v_s) && $stable(dv_v_s))
	// a valid matrix never yields a zero root
	`RMQ_ASSERT_NEVER(a_root_zero, clk, arst_n, sq_v_s[R_W] && !sq_side_s[R_W].bad && root == 0)
endmodule
